@@ src/rmsd_pkg.sv @@
// Shared types and constants for the paired coordinate RMSD core.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package rmsd_pkg;

  // Field and datapath widths.
  localparam int COORD_W  = 25;   // signed coordinate, thousandths of an angstrom
  localparam int DIFF_W   = 26;   // magnitude of a coordinate difference
  localparam int SQ_W     = 52;   // one squared difference
  localparam int SUM3_W   = 54;   // dx^2 + dy^2 + dz^2
  localparam int ACC_W    = 64;   // running sum, also the divide/root shift register
  localparam int CNT_W    = 17;   // pair count
  localparam int ROOT_W   = 32;   // square root of a 64-bit value
  localparam int SREM_W   = 34;   // square root partial remainder
  localparam int DEV_W    = 25;   // reported deviation
  localparam int STEP_W   = 6;    // iteration counter

  // Stream widths.
  localparam int S_DATA_W = 152;  // six coordinates, padded to whole bytes
  localparam int M_DATA_W = 48;   // deviation and pair count, padded
  localparam int M_USER_W = 2;

  // Last iteration indexes of the divider and the root unit.
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ACC_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // input stream may transfer
    logic init;       // clear divider and root remainders
    logic div_step;   // one restoring division step
    logic sqrt_step;  // one square root digit step
    logic load_out;   // load the result register
    logic clear;      // clear sum, count and saturation mark
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_acc;   // the item marked last transfers this cycle
    logic pipe_busy;  // pairs still in the accumulate pipeline
    logic count_zero; // no pairs in the current set
    logic out_free;   // result register can be loaded
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/rmsd_ctrl.sv @@
// Sequencing state machine of the RMSD core: accumulate, drain, divide, root, emit.
// Depends on rmsd_pkg for the command and status structs.
`default_nettype none

module rmsd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rmsd_pkg::dp_status_t status,
  output rmsd_pkg::ctrl_cmd_t     cmd
);
  import rmsd_pkg::*;

  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      ST_ACC: begin
        cmd.take = 1'b1;
        if (status.last_acc) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Wait until the final pair has reached the running sum.
        if (!status.pipe_busy) begin
          cmd.init = 1'b1;
          if (status.count_zero) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_DIV;
            step_next  = DIV_LAST;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '0) begin
          state_next = ST_SQRT;
          step_next  = SQRT_LAST;
        end else begin
          step_next = step - 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step == '0) state_next = ST_LOAD;
        else step_next = step - 1'b1;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACC;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

`default_nettype wire

@@ src/rmsd_dp.sv @@
// Datapath of the RMSD core: squared-difference pipeline, saturating sum,
// bit-serial divider, digit-serial square root and the result register.
// Depends on rmsd_pkg; driven by rmsd_ctrl commands.
`default_nettype none

module rmsd_dp #(
  parameter int MAX_PAIRS = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rmsd_pkg::ctrl_cmd_t             cmd,
  output rmsd_pkg::dp_status_t                 status,
  input  wire logic                            s_axis_tvalid,
  input  wire logic [rmsd_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [rmsd_pkg::M_DATA_W-1:0]        m_axis_tdata,
  output logic [rmsd_pkg::M_USER_W-1:0]        m_axis_tuser
);
  import rmsd_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

  // Magnitude of the difference of two signed coordinates.
  function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [DIFF_W-1:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[DIFF_W-1] ? (~d + 1'b1) : d;
  endfunction

  logic                 accepted, use_pair;
  logic [CNT_W-1:0]     pair_count;
  logic                 sat_mark;
  logic [ACC_W-1:0]     acc;
  logic [DIFF_W-1:0]    d1 [3];
  logic [SQ_W-1:0]      sq2 [3];
  logic [SUM3_W-1:0]    sum3;
  logic                 v1, v2, v3;
  logic [ACC_W:0]       acc_sum;
  logic                 acc_full;
  logic [CNT_W-1:0]     drem;
  logic [CNT_W:0]       drem_shift, drem_diff;
  logic                 qbit;
  logic [SREM_W-1:0]    srem;
  logic [SREM_W+1:0]    srem_shift, srem_trial, srem_diff;
  logic                 rbit;
  logic [ROOT_W-1:0]    root;
  logic [DEV_W-1:0]     dev_val;

  assign accepted = s_axis_tvalid & cmd.take;
  assign use_pair = accepted & s_axis_tuser & (pair_count < MAX_CNT);

  // Stage 1: coordinate difference magnitudes.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1[i] <= abs_diff(s_axis_tdata[i*COORD_W +: COORD_W],
                        s_axis_tdata[(i+3)*COORD_W +: COORD_W]);
    end
  end

  // Stage 2: squares, one multiplier per axis.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq2[i] <= d1[i] * d1[i];
    end
  end

  // Stage 3: sum of the three squares.
  always_ff @(posedge clk) begin
    sum3 <= SUM3_W'(sq2[0]) + SUM3_W'(sq2[1]) + SUM3_W'(sq2[2]);
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= use_pair;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 4: saturating addition into the running sum.
  assign acc_sum  = {1'b0, acc} + (ACC_W+1)'(sum3);
  assign acc_full = acc_sum[ACC_W] | (&acc_sum[ACC_W-1:0]);

  // Restoring division step: the sum shifts out, the quotient shifts in.
  assign drem_shift = {drem, acc[ACC_W-1]};
  assign drem_diff  = drem_shift - {1'b0, pair_count};
  assign qbit       = (drem_shift >= {1'b0, pair_count});

  // Square root digit step on the quotient, two bits per step.
  assign srem_shift = {srem, acc[ACC_W-1 -: 2]};
  assign srem_trial = {2'b00, root, 2'b01};
  assign srem_diff  = srem_shift - srem_trial;
  assign rbit       = (srem_shift >= srem_trial);

  // Running sum, reused as the shift register of the divider and root unit.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      acc      <= '0;
      sat_mark <= 1'b0;
    end else if (v3) begin
      acc <= acc_full ? '1 : acc_sum[ACC_W-1:0];
      if (acc_full) sat_mark <= 1'b1;
    end else if (cmd.div_step) begin
      acc <= {acc[ACC_W-2:0], qbit};
    end else if (cmd.sqrt_step) begin
      acc <= {acc[ACC_W-3:0], 2'b00};
    end
  end

  // Pair counter, advanced when a pair is taken in.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) pair_count <= '0;
    else if (use_pair) pair_count <= pair_count + 1'b1;
  end

  // Divider and root remainders and the root.
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      drem <= '0;
      srem <= '0;
      root <= '0;
    end else if (cmd.div_step) begin
      drem <= qbit ? drem_diff[CNT_W-1:0] : drem_shift[CNT_W-1:0];
    end else if (cmd.sqrt_step) begin
      srem <= rbit ? srem_diff[SREM_W-1:0] : srem_shift[SREM_W-1:0];
      root <= {root[ROOT_W-2:0], rbit};
    end
  end

  // Deviation, clamped to the field range; zero for an empty set.
  always_comb begin
    if (pair_count == '0) dev_val = '0;
    else if (|root[ROOT_W-1:DEV_W]) dev_val = '1;
    else dev_val = root[DEV_W-1:0];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tdata <= M_DATA_W'({pair_count, dev_val});
      m_axis_tuser <= {sat_mark, pair_count == '0};
    end
  end

  assign status.last_acc   = accepted & s_axis_tlast;
  assign status.pipe_busy  = v1 | v2 | v3;
  assign status.count_zero = (pair_count == '0);
  assign status.out_free   = ~m_axis_tvalid | m_axis_tready;

endmodule

`default_nettype wire

@@ src/paired_coordinate_rmsd_core.sv @@
// Top level of the paired coordinate RMSD core.
// Instantiates rmsd_ctrl and rmsd_dp; uses rmsd_pkg.
//
//   Channel   Direction  Fields
//   s_axis    in         tdata: six coordinates; tuser: pair_valid; tlast: last_pair
//   m_axis    out        tdata: deviation, pairs_used; tuser: empty_set, sum_saturated
//
// Pairs transfer one per cycle into a four-stage squared-difference pipeline.
// After the item marked last the input stalls while the pipeline drains, the
// bit-serial divider runs its 64 steps and the square root unit its 32, and the
// result register is loaded. An empty set stalls only to drain and load.
// The next set streams in while a result waits on m_axis; the load waits for it.
// Reset is synchronous and clears the sum, count, flags and all valid bits.
`default_nettype none

module paired_coordinate_rmsd_core #(
  parameter int MAX_PAIRS = 65536
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [24:0] first_x, [49:25] first_y, [74:50] first_z, [99:75] second_x,
  // [124:100] second_y, [149:125] second_z, [151:150] zero
  input  wire logic [rmsd_pkg::S_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tuser,  // [0] pair_valid
  input  wire logic                            s_axis_tlast,  // last_pair
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [24:0] deviation, [41:25] pairs_used, [47:42] zero
  output logic [rmsd_pkg::M_DATA_W-1:0]        m_axis_tdata,
  // [0] empty_set, [1] sum_saturated
  output logic [rmsd_pkg::M_USER_W-1:0]        m_axis_tuser
);
  import rmsd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign s_axis_tready = cmd.take;

  // Sequencer.
  rmsd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Arithmetic and result register.
  rmsd_dp #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ src/rmsd_checker.sv @@
// Port-level checks for the paired coordinate RMSD core, bound to the top level.
// Depends on rmsd_pkg for stream widths.
`default_nettype none

module rmsd_checker #(
  parameter int MAX_PAIRS = 65536
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            s_axis_tlast,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [rmsd_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input wire logic [rmsd_pkg::M_USER_W-1:0]   m_axis_tuser
);
  import rmsd_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAIRS);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The input stalls after the closing transfer of a set.
  a_close_stall: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after the closing transfer");

  // An empty set reports zero deviation and zero pairs.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[41:0] == '0)
    else $error("empty set with nonzero deviation or count");

  // A zero pair count is flagged as empty.
  a_zero_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[41:25] == '0 |-> m_axis_tuser[0])
    else $error("zero pairs without the empty flag");

  // The count never exceeds the pair limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[41:25] <= MAX_CNT)
    else $error("pair count above the limit");

endmodule

bind paired_coordinate_rmsd_core rmsd_checker #(
  .MAX_PAIRS (MAX_PAIRS)
) u_rmsd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
